### rtl/svp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants for the space-vector PWM timing block.
// ----------------------------------------------------------------------------
package svp_pkg;

  localparam int ANGLE_BITS = 16;
  localparam logic [15:0] ANGLE_MASK = 16'(17'h1FFFF << (16 - ANGLE_BITS));

  // sine polynomial coefficients, Q.16
  localparam int SIN_A = 102944;
  localparam int SIN_B = 42047;
  localparam int SIN_C = 4639;

  localparam int K_SQRT3      = 113512;
  localparam int K_HALF_SQRT3 = 56756;
  localparam int K_THREE_HALF = 98304;
  localparam int ONE_PERIOD   = 65536;

  localparam logic [15:0] INV_BUS_RESET = 16'd5461;
  localparam logic [15:0] PERIOD_RESET  = 16'd5600;

  // configuration register indexes
  localparam logic [7:0] REG_INV_BUS_VOLTAGE = 8'd0;
  localparam logic [7:0] REG_PERIOD_COUNT    = 8'd1;

  // sector codes
  localparam logic [2:0] SECTOR_ZERO = 3'd0;
  localparam logic [2:0] SECTOR_1    = 3'd1;
  localparam logic [2:0] SECTOR_2    = 3'd2;
  localparam logic [2:0] SECTOR_3    = 3'd3;
  localparam logic [2:0] SECTOR_4    = 3'd4;
  localparam logic [2:0] SECTOR_5    = 3'd5;
  localparam logic [2:0] SECTOR_6    = 3'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // active-vector times handed from front to back
  typedef struct packed {
    logic [2:0]  sector;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [32:0] sum;
  } svp_item_t;

endpackage

### rtl/svp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_front
// Pipelined sine/cosine, inverse Park, sector tests and active-vector times.
// ----------------------------------------------------------------------------
module svp_front import svp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [15:0] volt_q,
  input  logic signed [15:0] volt_d,
  input  logic [15:0]       elec_angle,
  input  logic [15:0]       inv_bus_voltage,
  output logic              push_valid,
  input  logic              push_ready,
  output svp_item_t         push_item
);

  function automatic logic [16:0] fold(input logic [15:0] a);
    logic [16:0] z;
    z = {1'b0, a[13:0], 2'b00};
    fold = a[14] ? 17'(17'd65536 - z) : z;
  endfunction

  logic [10:1] vld;
  logic        en;

  assign en         = !(vld[10] && !push_ready);
  assign in_ready   = en;
  assign push_valid = vld[10];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_valid};
    end
  end

  // stage 1: angle folding
  logic [15:0] ang_s, ang_c;
  assign ang_s = elec_angle & ANGLE_MASK;
  assign ang_c = ang_s + 16'd16384;

  logic [16:0]        zs_p [1:4];
  logic [16:0]        zc_p [1:4];
  logic               ns_p [1:4];
  logic               nc_p [1:4];
  logic signed [15:0] vq_p [1:5];
  logic signed [15:0] vd_p [1:5];

  // stage 2..5: polynomial
  logic [33:0] sq_s, sq_c;
  logic [16:0] z2s2, z2c2, z2s3, z2c3;
  logic [29:0] cz_s, cz_c;
  logic [15:0] t2s3, t2c3;
  logic [32:0] m_s, m_c;
  logic [16:0] t4s4, t4c4;
  logic [33:0] r_s, r_c;
  logic signed [17:0] sn5, cs5;

  assign sq_s = 34'(zs_p[1]) * 34'(zs_p[1]);
  assign sq_c = 34'(zc_p[1]) * 34'(zc_p[1]);
  assign cz_s = 30'(SIN_C) * 30'(z2s2);
  assign cz_c = 30'(SIN_C) * 30'(z2c2);
  assign m_s  = 33'(z2s3) * 33'(t2s3);
  assign m_c  = 33'(z2c3) * 33'(t2c3);
  assign r_s  = 34'(zs_p[4]) * 34'(t4s4);
  assign r_c  = 34'(zc_p[4]) * 34'(t4c4);

  // stage 6..10
  logic signed [33:0] p_dc, p_qs, p_ds, p_qc;
  logic signed [34:0] ua7, ub7;
  logic signed [55:0] ua_w, ub_w, q_x, q_y, q_z, tst_b, tst_c;
  logic signed [39:0] vx8, vy8, vz8;
  logic [2:0]         sec8, sec9, sec10;
  logic signed [38:0] ph_x9, ph_y9, ph_z9;
  logic [33:0]        pl_x9, pl_y9, pl_z9;
  logic signed [56:0] fx, fy, fz;
  logic signed [31:0] px10, py10, pz10;

  assign ua_w  = 56'(ua7);
  assign ub_w  = 56'(ub7);
  assign q_x   = 56'(K_THREE_HALF) * ua_w + 56'(K_HALF_SQRT3) * ub_w;
  assign q_y   = 56'(K_HALF_SQRT3) * ub_w - 56'(K_THREE_HALF) * ua_w;
  assign q_z   = 56'(K_SQRT3) * ub_w;
  assign tst_b = 56'(K_SQRT3) * ua_w - (ub_w <<< 16);
  assign tst_c = -(56'(K_SQRT3) * ua_w) - (ub_w <<< 16);

  assign fx = (57'(ph_x9) <<< 18) + 57'($signed({1'b0, pl_x9}));
  assign fy = (57'(ph_y9) <<< 18) + 57'($signed({1'b0, pl_y9}));
  assign fz = (57'(ph_z9) <<< 18) + 57'($signed({1'b0, pl_z9}));

  always_ff @(posedge clk) begin
    if (en) begin
      zs_p[1] <= fold(ang_s);
      zc_p[1] <= fold(ang_c);
      ns_p[1] <= ang_s[15];
      nc_p[1] <= ang_c[15];
      vq_p[1] <= volt_q;
      vd_p[1] <= volt_d;
      for (int i = 2; i <= 4; i++) begin
        zs_p[i] <= zs_p[i-1];
        zc_p[i] <= zc_p[i-1];
        ns_p[i] <= ns_p[i-1];
        nc_p[i] <= nc_p[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
        vq_p[i] <= vq_p[i-1];
        vd_p[i] <= vd_p[i-1];
      end
      z2s2 <= sq_s[32:16];
      z2c2 <= sq_c[32:16];
      z2s3 <= z2s2;
      z2c3 <= z2c2;
      t2s3 <= 16'(SIN_B) - {2'b00, cz_s[29:16]};
      t2c3 <= 16'(SIN_B) - {2'b00, cz_c[29:16]};
      t4s4 <= 17'(SIN_A) - {1'b0, m_s[31:16]};
      t4c4 <= 17'(SIN_A) - {1'b0, m_c[31:16]};
      sn5  <= ns_p[4] ? -$signed({1'b0, r_s[32:16]}) : $signed({1'b0, r_s[32:16]});
      cs5  <= nc_p[4] ? -$signed({1'b0, r_c[32:16]}) : $signed({1'b0, r_c[32:16]});
      p_dc <= vd_p[5] * cs5;
      p_qs <= vq_p[5] * sn5;
      p_ds <= vd_p[5] * sn5;
      p_qc <= vq_p[5] * cs5;
      ua7  <= 35'(p_dc) - 35'(p_qs);
      ub7  <= 35'(p_ds) + 35'(p_qc);
      sec8 <= {tst_c > 56'sd0, tst_b > 56'sd0, ub7 > 35'sd0};
      vx8  <= 40'(q_x >>> 16);
      vy8  <= 40'(q_y >>> 16);
      vz8  <= 40'(q_z >>> 16);
      // split the 40-bit projection to keep the multipliers narrow
      sec9  <= sec8;
      ph_x9 <= $signed(vx8[39:18]) * $signed({1'b0, inv_bus_voltage});
      ph_y9 <= $signed(vy8[39:18]) * $signed({1'b0, inv_bus_voltage});
      ph_z9 <= $signed(vz8[39:18]) * $signed({1'b0, inv_bus_voltage});
      pl_x9 <= 34'(vx8[17:0]) * 34'(inv_bus_voltage);
      pl_y9 <= 34'(vy8[17:0]) * 34'(inv_bus_voltage);
      pl_z9 <= 34'(vz8[17:0]) * 34'(inv_bus_voltage);
      sec10 <= sec9;
      px10  <= 32'(fx >>> 24);
      py10  <= 32'(fy >>> 24);
      pz10  <= 32'(fz >>> 24);
    end
  end

  logic signed [31:0] tx, ty;

  always_comb begin
    case (sec10)
      SECTOR_1: begin tx = py10;  ty = px10;  end
      SECTOR_2: begin tx = px10;  ty = -pz10; end
      SECTOR_3: begin tx = -py10; ty = pz10;  end
      SECTOR_4: begin tx = -pz10; ty = py10;  end
      SECTOR_5: begin tx = pz10;  ty = -px10; end
      default:  begin tx = -px10; ty = -py10; end
    endcase
  end

  assign push_item.sector = sec10;
  assign push_item.tx     = tx;
  assign push_item.ty     = ty;
  assign push_item.sum    = 33'(tx) + 33'(ty);

endmodule

### rtl/svp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_queue
// Small FIFO between the front pipeline and the back sequencer.
// ----------------------------------------------------------------------------
module svp_queue import svp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  svp_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output svp_item_t pop_item
);

  svp_item_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push, do_pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end
  end

endmodule

### rtl/svp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_back
// Overmodulation scaling, edge times and saturated compare counts.
// ----------------------------------------------------------------------------
module svp_back import svp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  svp_item_t   q_item,
  input  logic [15:0] period_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] phase_a_compare,
  output logic [15:0] phase_b_compare,
  output logic [15:0] phase_c_compare,
  output logic [2:0]  sector_code
);

  typedef enum logic [2:0] {S_LOAD, S_DIV, S_EDGE, S_MUL, S_DONE} state_t;

  function automatic logic [15:0] sat_cmp(input logic [32:0] ph, input logic [32:0] pl);
    logic [50:0] f;
    f = ({18'b0, ph} << 17) + {18'b0, pl};
    sat_cmp = (f[50:34] != '0) ? 16'hFFFF : f[33:18];
  endfunction

  state_t             state;
  logic [2:0]         sector;
  logic signed [31:0] tx, ty;
  logic [32:0]        dsor, rem_x, rem_y;
  logic [31:0]        sh_x, sh_y;
  logic               neg_x, neg_y;
  logic [4:0]         cnt;
  logic [33:0]        ea_m, eb_m, ec_m;
  logic [32:0]        pl_a, pl_b, pl_c, ph_a, ph_b, ph_c;

  assign q_ready = (state == S_LOAD);

  logic [31:0] mag_x, mag_y;
  assign mag_x = q_item.tx[31] ? 32'(-$signed(q_item.tx)) : q_item.tx;
  assign mag_y = q_item.ty[31] ? 32'(-$signed(q_item.ty)) : q_item.ty;

  // one restoring step per cycle for both times
  logic [33:0] cat_x, cat_y;
  logic        ge_x, ge_y;
  logic [32:0] rnx_x, rnx_y;
  logic [31:0] quo_x, quo_y;
  assign cat_x = {rem_x, sh_x[31]};
  assign cat_y = {rem_y, sh_y[31]};
  assign ge_x  = cat_x >= {1'b0, dsor};
  assign ge_y  = cat_y >= {1'b0, dsor};
  assign rnx_x = ge_x ? 33'(cat_x - {1'b0, dsor}) : 33'(cat_x);
  assign rnx_y = ge_y ? 33'(cat_y - {1'b0, dsor}) : 33'(cat_y);
  assign quo_x = {sh_x[30:0], ge_x};
  assign quo_y = {sh_y[30:0], ge_y};

  logic signed [34:0] ea, eb, ec;
  assign ea = 35'sd65536 - (35'(tx) + 35'(ty));
  assign eb = (35'(tx) <<< 1) + ea;
  assign ec = (35'(ty) <<< 1) + eb;

  logic [15:0] ca, cb, cc;
  assign ca = sat_cmp(ph_a, pl_a);
  assign cb = sat_cmp(ph_b, pl_b);
  assign cc = sat_cmp(ph_c, pl_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      // S_DONE always leaves out_valid set, so only clear it elsewhere
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            sector <= q_item.sector;
            tx     <= $signed(q_item.tx);
            ty     <= $signed(q_item.ty);
            dsor   <= q_item.sum;
            rem_x  <= {17'b0, mag_x[31:16]};
            rem_y  <= {17'b0, mag_y[31:16]};
            sh_x   <= {mag_x[15:0], 16'b0};
            sh_y   <= {mag_y[15:0], 16'b0};
            neg_x  <= q_item.tx[31];
            neg_y  <= q_item.ty[31];
            cnt    <= '0;
            if ($signed(q_item.sum) > 33'sd65536) begin
              state <= S_DIV;
            end else begin
              state <= S_EDGE;
            end
          end
        end
        S_DIV: begin
          rem_x <= rnx_x;
          rem_y <= rnx_y;
          sh_x  <= quo_x;
          sh_y  <= quo_y;
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            tx    <= neg_x ? -$signed(quo_x) : $signed(quo_x);
            ty    <= neg_y ? -$signed(quo_y) : $signed(quo_y);
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          ea_m  <= (ea > 35'sd0) ? ea[33:0] : '0;
          eb_m  <= (eb > 35'sd0) ? eb[33:0] : '0;
          ec_m  <= (ec > 35'sd0) ? ec[33:0] : '0;
          state <= S_MUL;
        end
        S_MUL: begin
          pl_a  <= 33'(ea_m[16:0]) * 33'(period_count);
          pl_b  <= 33'(eb_m[16:0]) * 33'(period_count);
          pl_c  <= 33'(ec_m[16:0]) * 33'(period_count);
          ph_a  <= 33'(ea_m[33:17]) * 33'(period_count);
          ph_b  <= 33'(eb_m[33:17]) * 33'(period_count);
          ph_c  <= 33'(ec_m[33:17]) * 33'(period_count);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            sector_code <= sector;
            state       <= S_LOAD;
            case (sector)
              SECTOR_1: begin
                phase_a_compare <= cb; phase_b_compare <= ca; phase_c_compare <= cc;
              end
              SECTOR_2: begin
                phase_a_compare <= ca; phase_b_compare <= cc; phase_c_compare <= cb;
              end
              SECTOR_3: begin
                phase_a_compare <= ca; phase_b_compare <= cb; phase_c_compare <= cc;
              end
              SECTOR_4: begin
                phase_a_compare <= cc; phase_b_compare <= cb; phase_c_compare <= ca;
              end
              SECTOR_5: begin
                phase_a_compare <= cc; phase_b_compare <= ca; phase_c_compare <= cb;
              end
              SECTOR_6: begin
                phase_a_compare <= cb; phase_b_compare <= cc; phase_c_compare <= ca;
              end
              default: begin
                phase_a_compare <= '0; phase_b_compare <= '0; phase_c_compare <= '0;
                sector_code     <= SECTOR_ZERO;
              end
            endcase
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### rtl/space_vector_pwm_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_timing
// d/q voltage and angle in, three centered compare counts and sector out.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid/in_ready, volt_q, volt_d, elec_angle    | input
//  out     | out_valid/out_ready, phase_[abc]_compare, sector | output
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data         | input
//
//  The front pipeline, 10 stages deep, takes one transfer per cycle while the
//  4-entry queue has room. The back sequencer goes S_LOAD, S_EDGE, S_MUL,
//  S_DONE, adding the restoring divider S_DIV when the active times overflow
//  one period, and takes a new item only in S_LOAD. Synchronous reset empties
//  the pipeline and queue and loads the register defaults. A stalled output
//  backs up into the queue, then the front; cfg_ready is always high.
// ----------------------------------------------------------------------------
module space_vector_pwm_timing import svp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [15:0] volt_q,
  input  logic signed [15:0] volt_d,
  input  logic [15:0]       elec_angle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       phase_a_compare,
  output logic [15:0]       phase_b_compare,
  output logic [15:0]       phase_c_compare,
  output logic [2:0]        sector_code,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic [15:0] inv_bus_voltage, period_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_bus_voltage <= INV_BUS_RESET;
      period_count    <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_INV_BUS_VOLTAGE) inv_bus_voltage <= cfg_data;
      if (cfg_index == REG_PERIOD_COUNT)    period_count    <= cfg_data;
    end
  end

  logic      push_valid, push_ready, pop_valid, pop_ready;
  svp_item_t push_item, pop_item;

  svp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .volt_q          (volt_q),
    .volt_d          (volt_d),
    .elec_angle      (elec_angle),
    .inv_bus_voltage (inv_bus_voltage),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  svp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  svp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_item          (pop_item),
    .period_count    (period_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase_a_compare (phase_a_compare),
    .phase_b_compare (phase_b_compare),
    .phase_c_compare (phase_c_compare),
    .sector_code     (sector_code)
  );

endmodule

### rtl/svp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_port_checks
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module svp_port_checks import svp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] phase_a_compare,
  input logic [15:0] phase_b_compare,
  input logic [15:0] phase_c_compare,
  input logic [2:0]  sector_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(phase_a_compare) && $stable(phase_b_compare)
      && $stable(phase_c_compare) && $stable(sector_code))
    else $error("result changed while stalled");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_code <= SECTOR_6)
    else $error("sector seven reported");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_code == SECTOR_ZERO |-> phase_a_compare == 16'd0
      && phase_b_compare == 16'd0 && phase_c_compare == 16'd0)
    else $error("zero vector with nonzero compares");

endmodule

bind space_vector_pwm_timing svp_port_checks u_chk (.*);

### tb/svp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_checker
// Watches the input, output and register channels of the space-vector PWM
// block, computes the expected compares and sector for every input transfer
// and compares each output transfer against the oldest pending expectation.
// ----------------------------------------------------------------------------
module svp_checker import svp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] volt_q,
  input  logic signed [15:0] volt_d,
  input  logic [15:0]        elec_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        phase_a_compare,
  input  logic [15:0]        phase_b_compare,
  input  logic [15:0]        phase_c_compare,
  input  logic [2:0]         sector_code,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
    logic [2:0]  sec;
  } pwm_result_t;

  pwm_result_t expected_pwm[$];
  longint inv_bus, period;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;  // arithmetic shift floors
  endfunction

  function automatic longint sine_of(logic [15:0] a);
    logic [1:0] quad;
    longint z, z2, t, r;
    quad = a[15:14];
    z = longint'(a[13:0]) << 2;
    if (quad[0]) z = ONE_PERIOD - z;
    z2 = (z * z) >> 16;
    t = (SIN_C * z2) >> 16;
    t = SIN_B - t;
    t = (z2 * t) >> 16;
    t = SIN_A - t;
    r = (z * t) >> 16;
    return quad[1] ? -r : r;
  endfunction

  function automatic longint active_time(longint q40);
    return floor_sh(floor_sh(q40, 16) * inv_bus, 24);
  endfunction

  function automatic logic [15:0] edge_count(longint e18);
    longint c;
    if (e18 <= 0) return 16'd0;
    c = floor_sh(e18 * period, 18);
    return (c > 65535) ? 16'hFFFF : 16'(c);
  endfunction

  function automatic pwm_result_t svpwm_predict(logic signed [15:0] vq,
                                               logic signed [15:0] vd,
                                               logic [15:0] ang_in);
    logic [15:0] ang;
    longint sn, cs, ua, ub, px, py, pz, tx, ty, tsum, ea, eb, ec;
    logic [2:0] sec;
    pwm_result_t r;
    ang = ang_in & ANGLE_MASK;
    sn = sine_of(ang);
    cs = sine_of(ang + 16'd16384);
    ua = longint'(vd) * cs - longint'(vq) * sn;
    ub = longint'(vd) * sn + longint'(vq) * cs;
    sec = 3'd0;
    if (ub > 0) sec = sec + 3'd1;
    if (K_SQRT3 * ua - ONE_PERIOD * ub > 0) sec = sec + 3'd2;
    if (-K_SQRT3 * ua - ONE_PERIOD * ub > 0) sec = sec + 3'd4;
    px = active_time(K_THREE_HALF * ua + K_HALF_SQRT3 * ub);
    py = active_time(-K_THREE_HALF * ua + K_HALF_SQRT3 * ub);
    pz = active_time(K_SQRT3 * ub);
    case (sec)
      SECTOR_1: begin tx = py;  ty = px;  end
      SECTOR_2: begin tx = px;  ty = -pz; end
      SECTOR_3: begin tx = -py; ty = pz;  end
      SECTOR_4: begin tx = -pz; ty = py;  end
      SECTOR_5: begin tx = pz;  ty = -px; end
      default:  begin tx = -px; ty = -py; end
    endcase
    tsum = tx + ty;
    if (tsum > ONE_PERIOD) begin
      tx = (tx * ONE_PERIOD) / tsum;
      ty = (ty * ONE_PERIOD) / tsum;
    end
    ea = ONE_PERIOD - (tx + ty);
    eb = 2 * tx + ea;
    ec = 2 * ty + eb;
    r = '0;
    r.sec = sec;
    case (sec)
      SECTOR_1: begin r.ca = edge_count(eb); r.cb = edge_count(ea); r.cc = edge_count(ec); end
      SECTOR_2: begin r.ca = edge_count(ea); r.cb = edge_count(ec); r.cc = edge_count(eb); end
      SECTOR_3: begin r.ca = edge_count(ea); r.cb = edge_count(eb); r.cc = edge_count(ec); end
      SECTOR_4: begin r.ca = edge_count(ec); r.cb = edge_count(eb); r.cc = edge_count(ea); end
      SECTOR_5: begin r.ca = edge_count(ec); r.cb = edge_count(ea); r.cc = edge_count(eb); end
      SECTOR_6: begin r.ca = edge_count(eb); r.cb = edge_count(ec); r.cc = edge_count(ea); end
      default:  r.sec = SECTOR_ZERO;
    endcase
    return r;
  endfunction

  assign pending_count = expected_pwm.size();

  always @(posedge clk) begin
    pwm_result_t want, got;
    if (rst) begin
      inv_bus <= INV_BUS_RESET;
      period <= PERIOD_RESET;
      expected_pwm.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {phase_a_compare, phase_b_compare, phase_c_compare, sector_code};
        if (expected_pwm.size() == 0) begin
          if (fail_count < 10) $display("unexpected output transfer %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pwm.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp a=%0d b=%0d c=%0d s=%0d got a=%0d b=%0d c=%0d s=%0d",
                       want.ca, want.cb, want.cc, want.sec,
                       got.ca, got.cb, got.cc, got.sec);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_pwm.push_back(svpwm_predict(volt_q, volt_d, elec_angle));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INV_BUS_VOLTAGE) inv_bus <= cfg_data;
        else if (cfg_index == REG_PERIOD_COUNT) period <= cfg_data;
      end
    end
  end

endmodule

### tb/tb_space_vector_pwm_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_space_vector_pwm_timing
// Directed and random d/q/angle commands through several register settings
// and idle/stall mixes; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_timing;
  import svp_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [15:0] volt_q, volt_d;
  logic [15:0] elec_angle, phase_a_compare, phase_b_compare, phase_c_compare;
  logic [2:0] sector_code;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending_count;
  int send_idle_pct, recv_stall_pct, hold_cycles;
  logic hold_req;

  space_vector_pwm_timing dut (.*);
  svp_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("space_vector_pwm_timing test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // in_valid drops only in idle cycles or in drain
  task automatic send_cmd(logic [15:0] q, logic [15:0] d, logic [15:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    volt_q <= q;
    volt_d <= d;
    elec_angle <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_volt();
    case ($urandom_range(3))
      0: return 16'($urandom_range(2047)) - 16'd1024;   // modest, linear region
      1: return 16'($urandom_range(8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dq[8];
    in_valid = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    volt_q = 0; volt_d = 0; elec_angle = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero vector, field extremes, sectors around a turn
    dq = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0100, 16'hFF00, 16'h0C00, 16'h0001, 16'hFFFF};
    send_cmd(16'h0000, 16'h0000, 16'h0000);
    send_cmd(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_cmd(16'h8000, 16'h8000, 16'h4000);
    send_cmd(16'h7FFF, 16'h8000, 16'h8000);
    send_cmd(16'h8000, 16'h7FFF, 16'hC000);
    for (int i = 0; i < 12; i++)
      send_cmd(16'h0000, 16'h0100, 16'(i * 5461 + 100));
    for (int i = 0; i < 8; i++)
      send_cmd(dq[i], dq[7 - i], 16'($urandom));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_INV_BUS_VOLTAGE, 16'd1); write_reg(REG_PERIOD_COUNT, 16'hFFFF); end
        1: begin write_reg(REG_INV_BUS_VOLTAGE, 16'hFFFF); write_reg(REG_PERIOD_COUNT, 16'd1); end
        2: begin write_reg(REG_INV_BUS_VOLTAGE, 16'd0); write_reg(REG_PERIOD_COUNT, 16'd0); end
        3: begin write_reg(8'd7, 16'h1234);
                 write_reg(REG_INV_BUS_VOLTAGE, 16'($urandom));
                 write_reg(REG_PERIOD_COUNT, 16'($urandom)); end
        default: begin write_reg(REG_INV_BUS_VOLTAGE, INV_BUS_RESET);
                       write_reg(REG_PERIOD_COUNT, PERIOD_RESET); end
      endcase
      cfg_valid <= 1'b0;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (phase == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      for (int n = 0; n < 100; n++)
        send_cmd(rand_volt(), rand_volt(), 16'($urandom));
      drain();
    end

    if (fail_count == 0) $display("space_vector_pwm_timing test passed");
    else $display("space_vector_pwm_timing test failed");
    $finish;
  end

endmodule
